// File: design/rgbe_pkg.sv
package rgbe_pkg;

    // Channel order inside a scanline
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_EXP   = 2'd3;

    // Count byte decoding
    localparam logic [7:0] RUN_THRESHOLD = 8'd128;
    localparam logic [6:0] RUN_MASK      = 7'h7f;

    // Result bus width: 93 bits of fields, padded to whole bytes
    localparam int OUT_W = 96;

    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_EXPO,
        KIND_FLAT
    } span_kind_t;

    // Work handed from the parser to the column sweep engine
    typedef struct packed {
        span_kind_t  kind;
        logic [1:0]  lane;
        logic [7:0]  value;
        logic [7:0]  ncols;
        logic [15:0] row;
        logic [23:0] rgb;
    } span_cmd_t;

endpackage

// File: design/rgbe_ram.sv
module rgbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/rgbe_span.sv
module rgbe_span #(
    parameter int DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  rgbe_pkg::span_cmd_t           cmd,
    input  logic [$clog2(DEPTH)-1:0]      start_addr,
    output logic                          idle,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rgbe_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast
);

    import rgbe_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLAT,
        S_SWEEP
    } span_state_t;

    span_state_t       state_reg, state_next;
    span_kind_t        kind_reg, kind_next;
    logic [1:0]        lane_reg, lane_next;
    logic [7:0]        value_reg, value_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        left_reg, left_next;
    logic [15:0]       row_reg, row_next;
    logic [23:0]       rgb_reg, rgb_next;
    logic              half_reg, half_next;
    logic [23:0]       p0_rgb_reg, p0_rgb_next;
    logic [11:0]       p0_col_reg, p0_col_next;

    logic              out_valid_reg, out_valid_next;
    logic [23:0]       o_first_rgb_reg, o_first_rgb_next;
    logic [7:0]        o_first_e_reg, o_first_e_next;
    logic [23:0]       o_second_rgb_reg, o_second_rgb_next;
    logic [7:0]        o_second_e_reg, o_second_e_next;
    logic              o_sv_reg, o_sv_next;
    logic [11:0]       o_col_reg, o_col_next;
    logic [15:0]       o_row_reg, o_row_next;
    logic              o_last_reg, o_last_next;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [23:0]       ram_wdata, ram_rdata;
    logic              out_free, last_col, advance;

    rgbe_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign last_col = (left_reg == 8'd1);
    assign idle     = (state_reg == S_IDLE);

    // Merge the new byte into its lane of the stored pixel
    always_comb
    begin
        ram_wdata = ram_rdata;
        case (lane_reg)
            CH_RED:   ram_wdata[23:16] = value_reg;
            CH_GREEN: ram_wdata[15:8]  = value_reg;
            default:  ram_wdata[7:0]   = value_reg;
        endcase
    end

    // Sweep control: one column per cycle, hold when the result register is full
    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        lane_next         = lane_reg;
        value_next        = value_reg;
        addr_next         = addr_reg;
        left_next         = left_reg;
        row_next          = row_reg;
        rgb_next          = rgb_reg;
        half_next         = half_reg;
        p0_rgb_next       = p0_rgb_reg;
        p0_col_next       = p0_col_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        o_first_rgb_next  = o_first_rgb_reg;
        o_first_e_next    = o_first_e_reg;
        o_second_rgb_next = o_second_rgb_reg;
        o_second_e_next   = o_second_e_reg;
        o_sv_next         = o_sv_reg;
        o_col_next        = o_col_reg;
        o_row_next        = o_row_reg;
        o_last_next       = o_last_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = addr_reg + ADDR_W'(1);
        advance           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next  = cmd.kind;
                    lane_next  = cmd.lane;
                    value_next = cmd.value;
                    left_next  = cmd.ncols;
                    row_next   = cmd.row;
                    rgb_next   = cmd.rgb;
                    addr_next  = start_addr;
                    half_next  = 1'b0;
                    if (cmd.kind == KIND_FLAT)
                    begin
                        state_next = S_FLAT;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = start_addr;
                        state_next = S_SWEEP;
                    end
                end
            end
            S_FLAT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    o_first_rgb_next  = rgb_reg;
                    o_first_e_next    = value_reg;
                    o_second_rgb_next = '0;
                    o_second_e_next   = '0;
                    o_sv_next         = 1'b0;
                    o_col_next        = 12'(addr_reg);
                    o_row_next        = row_reg;
                    o_last_next       = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                if (kind_reg == KIND_STORE)
                begin
                    ram_we = 1'b1;
                    if (last_col)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
                else if (!half_reg && !last_col)
                begin
                    // Hold the first pixel of a pair
                    p0_rgb_next = ram_rdata;
                    p0_col_next = 12'(addr_reg);
                    half_next   = 1'b1;
                    advance     = 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_first_e_next = value_reg;
                    o_row_next     = row_reg;
                    o_last_next    = last_col;
                    if (half_reg)
                    begin
                        o_first_rgb_next  = p0_rgb_reg;
                        o_second_rgb_next = ram_rdata;
                        o_second_e_next   = value_reg;
                        o_sv_next         = 1'b1;
                        o_col_next        = p0_col_reg;
                    end
                    else
                    begin
                        o_first_rgb_next  = ram_rdata;
                        o_second_rgb_next = '0;
                        o_second_e_next   = '0;
                        o_sv_next         = 1'b0;
                        o_col_next        = 12'(addr_reg);
                    end
                    half_next = 1'b0;
                    if (last_col)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance to the next column and fetch it
        if (advance)
        begin
            ram_re    = 1'b1;
            addr_next = addr_reg + ADDR_W'(1);
            left_next = left_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        lane_reg         <= lane_next;
        value_reg        <= value_next;
        addr_reg         <= addr_next;
        left_reg         <= left_next;
        row_reg          <= row_next;
        rgb_reg          <= rgb_next;
        p0_rgb_reg       <= p0_rgb_next;
        p0_col_reg       <= p0_col_next;
        o_first_rgb_reg  <= o_first_rgb_next;
        o_first_e_reg    <= o_first_e_next;
        o_second_rgb_reg <= o_second_rgb_next;
        o_second_e_reg   <= o_second_e_next;
        o_sv_reg         <= o_sv_next;
        o_col_reg        <= o_col_next;
        o_row_reg        <= o_row_next;
        o_last_reg       <= o_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'b000, o_row_reg, o_col_reg, o_sv_reg,
                       o_second_e_reg, o_second_rgb_reg[7:0], o_second_rgb_reg[15:8],
                       o_second_rgb_reg[23:16],
                       o_first_e_reg, o_first_rgb_reg[7:0], o_first_rgb_reg[15:8],
                       o_first_rgb_reg[23:16]};

endmodule

// File: design/rgbe_scanline_rle_decoder.sv
// Channel   Dir  Handshake                 Content
// s_*       in   s_tvalid / s_tready       pixel stream byte, restart flag
// m_*       out  m_tvalid / m_tready       one or two decoded RGBE pixels
// APB       in   psel, penable, pready     image_width (0x0), image_height (0x4)
//
// A byte that starts no sweep and no flat pixel leaves the input ready; the next byte can follow at once.
// A byte that fills n columns of a channel occupies the line store port with one
// read-modify-write or read per column; a flat pixel holds the input off until its result is loaded.
// A full result register stops the sweep; input is taken again once the sweep ends.
// rst_n clears the parser and the result register; the line store needs no clearing.
module rgbe_scanline_rle_decoder #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MIN_RLE_WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic [0:0]                 s_tuser,   // [0] new_image
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] first_red, [15:8] first_green, [23:16] first_blue, [31:24] first_exponent,
    // [39:32] second_red, [47:40] second_green, [55:48] second_blue,
    // [63:56] second_exponent, [64] second_valid, [76:65] column, [92:77] row
    output logic [rgbe_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tlast,   // last_of_run
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import rgbe_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (COL_W > 13) ? COL_W : 13;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_CODE,
        PH_RUNVAL,
        PH_LIT,
        PH_DONE
    } phase_t;

    logic [12:0]      width_reg;
    logic [15:0]      height_reg;

    phase_t           phase_reg, phase_next, ph;
    logic             flat_reg, flat_next, flat_c;
    logic [1:0]       chan_reg, chan_next, chan_c;
    logic [COL_W-1:0] col_reg, col_next, col_c;
    logic [15:0]      row_reg, row_next, row_c;
    logic [7:0]       rem_reg, rem_next, rem_c;
    logic [23:0]      held_reg, held_next, held_c;
    logic [1:0]       grp_reg, grp_next, grp_c;

    logic             accept, span_idle, cmd_valid, end_req, finish_req;
    span_cmd_t        cmd;
    logic [CMP_W-1:0] width_cmp;
    logic [COL_W-1:0] eff_width;
    logic [15:0]      eff_height;
    logic [7:0]       byte_in;
    logic [7:0]       span_cnt;
    logic [COL_W:0]   col_sum;
    logic [COL_W-1:0] col_after;
    logic             do_span;

    // Configuration registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd8;
            height_reg <= 16'd1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[12:0];
                REG_HEIGHT: height_reg <= pwdata[15:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {19'd0, width_reg};
            REG_HEIGHT: prdata = {16'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // Clamp width and height to their usable ranges
    always_comb
    begin
        width_cmp = CMP_W'(width_reg);
        if (width_cmp == '0)
        begin
            width_cmp = CMP_W'(1);
        end
        else if (width_cmp > CMP_W'(MAX_WIDTH))
        begin
            width_cmp = CMP_W'(MAX_WIDTH);
        end
        eff_width  = COL_W'(width_cmp);
        eff_height = (height_reg == 16'd0) ? 16'd1 : height_reg;
    end

    assign s_tready = span_idle;
    assign accept   = s_tvalid && s_tready;
    assign byte_in  = s_tdata;

    // Parser: one byte per accepted transaction
    always_comb
    begin
        ph     = phase_reg;
        flat_c = flat_reg;
        chan_c = chan_reg;
        col_c  = col_reg;
        row_c  = row_reg;
        rem_c  = rem_reg;
        held_c = held_reg;
        grp_c  = grp_reg;
        if (s_tuser[0])
        begin
            ph     = PH_HDR0;
            flat_c = 1'b0;
            chan_c = CH_RED;
            col_c  = '0;
            row_c  = '0;
            rem_c  = '0;
            held_c = '0;
            grp_c  = '0;
        end

        phase_next = ph;
        flat_next  = flat_c;
        chan_next  = chan_c;
        col_next   = col_c;
        row_next   = row_c;
        rem_next   = rem_c;
        held_next  = held_c;
        grp_next   = grp_c;
        end_req    = 1'b0;
        finish_req = 1'b0;
        do_span    = 1'b0;
        span_cnt   = 8'd0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        cmd.row    = row_c;

        if (!flat_c && ph == PH_HDR0 && CMP_W'(eff_width) < CMP_W'(MIN_RLE_WIDTH))
        begin
            flat_next = 1'b1;
            grp_next  = 2'd0;
        end

        if (ph == PH_DONE)
        begin
            flat_next = flat_c;
            grp_next  = grp_c;
        end
        else if (flat_next)
        begin
            // Flat pixels: gather R, G, B, emit on E
            if (grp_next != 2'd3)
            begin
                case (grp_next)
                    2'd0:    held_next[23:16] = byte_in;
                    2'd1:    held_next[15:8]  = byte_in;
                    default: held_next[7:0]   = byte_in;
                endcase
                grp_next = grp_next + 2'd1;
            end
            else
            begin
                grp_next  = 2'd0;
                cmd_valid = 1'b1;
                cmd.kind  = KIND_FLAT;
                cmd.value = byte_in;
                cmd.rgb   = held_c;
                col_next  = col_c + COL_W'(1);
                if (col_next >= eff_width)
                begin
                    end_req = 1'b1;
                end
            end
        end
        else
        begin
            unique case (ph)
                PH_HDR0:
                begin
                    held_next  = {byte_in, 16'd0};
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    held_next[15:8] = byte_in;
                    phase_next      = PH_HDR2;
                end
                PH_HDR2:
                begin
                    held_next[7:0] = byte_in;
                    if (held_c[23:16] != 8'd2 || held_c[15:8] != 8'd2 || byte_in[7])
                    begin
                        flat_next = 1'b1;
                        grp_next  = 2'd3;
                    end
                    else
                    begin
                        phase_next = PH_HDR3;
                    end
                end
                PH_HDR3:
                begin
                    phase_next = PH_CODE;
                    chan_next  = CH_RED;
                    col_next   = '0;
                end
                PH_CODE:
                begin
                    if (byte_in > RUN_THRESHOLD)
                    begin
                        rem_next   = {1'b0, byte_in[6:0] & RUN_MASK};
                        phase_next = PH_RUNVAL;
                    end
                    else if (byte_in != 8'd0)
                    begin
                        rem_next   = byte_in;
                        phase_next = PH_LIT;
                    end
                end
                PH_RUNVAL:
                begin
                    do_span    = 1'b1;
                    span_cnt   = rem_c;
                    rem_next   = 8'd0;
                    finish_req = 1'b1;
                end
                PH_LIT:
                begin
                    do_span  = 1'b1;
                    span_cnt = 8'd1;
                    if (rem_c != 8'd0)
                    begin
                        rem_next = rem_c - 8'd1;
                    end
                    if (rem_next == 8'd0)
                    begin
                        finish_req = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = ph;
                end
            endcase
        end

        // Columns covered by a run or literal, stopping at the width
        col_sum   = {1'b0, col_c} + (COL_W + 1)'(span_cnt);
        col_after = col_c;
        if (col_c < eff_width)
        begin
            col_after = (col_sum > {1'b0, eff_width}) ? eff_width : col_sum[COL_W-1:0];
        end
        if (do_span)
        begin
            col_next = col_after;
            if (col_after != col_c)
            begin
                cmd_valid = 1'b1;
                cmd.kind  = (chan_c == CH_EXP) ? KIND_EXPO : KIND_STORE;
                cmd.lane  = chan_c;
                cmd.value = byte_in;
                cmd.ncols = 8'(col_after - col_c);
            end
        end

        // Close the channel once its columns are done
        if (finish_req)
        begin
            phase_next = PH_CODE;
            if (col_next >= eff_width)
            begin
                if (chan_c == CH_EXP)
                begin
                    end_req = 1'b1;
                end
                else
                begin
                    chan_next = chan_c + 2'd1;
                    col_next  = '0;
                end
            end
        end

        // Close the scanline
        if (end_req)
        begin
            col_next  = '0;
            chan_next = CH_RED;
            if ({1'b0, row_c} + 17'd1 >= {1'b0, eff_height})
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                row_next = row_c + 16'd1;
                if (!flat_next)
                begin
                    phase_next = PH_HDR0;
                end
            end
        end

        cmd_valid = cmd_valid && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            flat_reg  <= 1'b0;
            chan_reg  <= CH_RED;
            col_reg   <= '0;
            row_reg   <= '0;
            rem_reg   <= '0;
            held_reg  <= '0;
            grp_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            flat_reg  <= flat_next;
            chan_reg  <= chan_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            rem_reg   <= rem_next;
            held_reg  <= held_next;
            grp_reg   <= grp_next;
        end
    end

    rgbe_span #(
        .DEPTH (MAX_WIDTH)
    ) u_span (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .start_addr (col_c[ADDR_W-1:0]),
        .idle       (span_idle),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// File: design/rgbe_checker.sv
module rgbe_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rgbe_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Clear the second slot when it holds no pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[64] |-> m_tdata[63:32] == 32'd0)
        else $error("empty second slot carries data");

    // Load a new result only while input is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (!$past(m_tvalid) || $past(m_tready)) |-> !$past(s_tready))
        else $error("result loaded while input was open");

endmodule

bind rgbe_scanline_rle_decoder rgbe_checker u_rgbe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/rgbe_scanline_rle_decoder_tb.sv
`timescale 1ns / 100ps

module rgbe_scanline_rle_decoder_tb;
    import rgbe_pkg::*;

    localparam int MAX_COLS         = 4096;
    localparam int MIN_RLE_COLS     = 8;
    localparam int RANDOM_ITEMS     = 380;
    localparam int SETTLE_CYCLES    = 200;
    localparam int WATCHDOG_CYCLES  = 4000;

    // Register byte addresses
    localparam logic [2:0] REG_WIDTH  = 3'h0;
    localparam logic [2:0] REG_HEIGHT = 3'h4;

    // First two bytes of an adaptive run-length scanline header
    localparam logic [7:0] HDR_MARK = 8'd2;

    typedef enum logic [2:0] {
        AWAIT_HDR0,
        AWAIT_HDR1,
        AWAIT_HDR2,
        AWAIT_HDR3,
        AWAIT_CODE,
        AWAIT_RUN_VALUE,
        AWAIT_LITERAL,
        IMAGE_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        restart;
    } stream_byte_t;

    typedef struct packed {
        logic [7:0]  first_red;
        logic [7:0]  first_green;
        logic [7:0]  first_blue;
        logic [7:0]  first_exponent;
        logic [7:0]  second_red;
        logic [7:0]  second_green;
        logic [7:0]  second_blue;
        logic [7:0]  second_exponent;
        logic        second_valid;
        logic [11:0] column;
        logic [15:0] row;
        logic        last_of_run;
    } pixel_pair_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    rgbe_scanline_rle_decoder #(
        .MAX_WIDTH     (MAX_COLS),
        .MIN_RLE_WIDTH (MIN_RLE_COLS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Stimulus and expectation stores
    stream_byte_t byte_stream[$];
    pixel_pair_t  pending_pixels[$];
    stream_byte_t next_byte;
    pixel_pair_t  want;
    bit           restart_next;
    int           bytes_made;
    int           mismatches;
    int           idle_cycles;
    bit           byte_taken;
    bit           activity;
    int           send_gap;
    int           hold_gap;
    bit           send_calm;
    bit           take_calm;

    // Decoder shadow state
    logic [23:0]  line_rgb [0:MAX_COLS-1];
    parse_phase_t phase;
    logic         flat;
    logic [1:0]   chan;
    logic [12:0]  col_pos;
    logic [15:0]  row_pos;
    logic [7:0]   left;
    logic [23:0]  held;
    logic [1:0]   grp;
    logic [12:0]  cfg_width;
    logic [15:0]  cfg_height;

    always #5 clk = ~clk;

    // ---------------- decoder shadow ----------------

    function automatic int line_width();
        if (cfg_width == 13'd0) return 1;
        if (int'(cfg_width) > MAX_COLS) return MAX_COLS;
        return int'(cfg_width);
    endfunction

    function automatic int line_count();
        return (cfg_height == 16'd0) ? 1 : int'(cfg_height);
    endfunction

    function automatic void restart_parse();
        phase   = AWAIT_HDR0;
        flat    = 1'b0;
        chan    = CH_RED;
        col_pos = '0;
        row_pos = '0;
        left    = '0;
        held    = '0;
        grp     = '0;
    endfunction

    function automatic void finish_line();
        col_pos = '0;
        chan    = CH_RED;
        if (int'(row_pos) + 1 >= line_count()) begin
            phase = IMAGE_DONE;
        end
        else begin
            row_pos = row_pos + 16'd1;
            if (!flat) phase = AWAIT_HDR0;
        end
    endfunction

    function automatic void close_count(int w);
        phase = AWAIT_CODE;
        if (int'(col_pos) >= w) begin
            if (chan == CH_EXP) begin
                finish_line();
            end
            else begin
                chan    = chan + 2'd1;
                col_pos = '0;
            end
        end
    endfunction

    // Apply one channel value to cnt columns; exponent bytes release pixel pairs
    function automatic void fill_columns(logic [7:0] v, int cnt, int w);
        pixel_pair_t pp;
        bit          half;
        int          made;
        int          c;
        int          i;
        half = 1'b0;
        made = 0;
        pp   = '0;
        for (i = 0; i < cnt; i++) begin
            c = int'(col_pos);
            if (c >= w || c >= MAX_COLS) break;
            if (chan == CH_RED) begin
                line_rgb[c][23:16] = v;
            end
            else if (chan == CH_GREEN) begin
                line_rgb[c][15:8] = v;
            end
            else if (chan == CH_BLUE) begin
                line_rgb[c][7:0] = v;
            end
            else if (!half) begin
                pp = '0;
                {pp.first_red, pp.first_green, pp.first_blue} = line_rgb[c];
                pp.first_exponent = v;
                pp.column = 12'(c);
                pp.row = row_pos;
                half = 1'b1;
            end
            else begin
                {pp.second_red, pp.second_green, pp.second_blue} = line_rgb[c];
                pp.second_exponent = v;
                pp.second_valid = 1'b1;
                pending_pixels.push_back(pp);
                made++;
                half = 1'b0;
            end
            col_pos = 13'(c + 1);
        end
        if (half) begin
            pending_pixels.push_back(pp);
            made++;
        end
        // Mark the final pixel pair released by this byte
        if (made > 0) begin
            pp = pending_pixels.pop_back();
            pp.last_of_run = 1'b1;
            pending_pixels.push_back(pp);
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic restart);
        pixel_pair_t pp;
        int          w;
        if (restart) restart_parse();
        w = line_width();
        if (phase == IMAGE_DONE) return;

        // Narrow lines never carry run-length scanlines
        if (!flat && phase == AWAIT_HDR0 && w < MIN_RLE_COLS) begin
            flat = 1'b1;
            grp  = 2'd0;
        end

        if (flat) begin
            if (grp < 2'd3) begin
                case (grp)
                    2'd0:    held[23:16] = b;
                    2'd1:    held[15:8]  = b;
                    default: held[7:0]   = b;
                endcase
                grp = grp + 2'd1;
            end
            else begin
                grp = 2'd0;
                pp  = '0;
                {pp.first_red, pp.first_green, pp.first_blue} = held;
                pp.first_exponent = b;
                pp.column         = col_pos[11:0];
                pp.row            = row_pos;
                pp.last_of_run    = 1'b1;
                pending_pixels.push_back(pp);
                col_pos = col_pos + 13'd1;
                if (int'(col_pos) >= w) finish_line();
            end
            return;
        end

        case (phase)
            AWAIT_HDR0: begin
                held  = {b, 16'h0000};
                phase = AWAIT_HDR1;
            end
            AWAIT_HDR1: begin
                held[15:8] = b;
                phase      = AWAIT_HDR2;
            end
            AWAIT_HDR2: begin
                held[7:0] = b;
                // Bad header: these three bytes open a flat pixel
                if (held[23:16] != HDR_MARK || held[15:8] != HDR_MARK || b[7]) begin
                    flat = 1'b1;
                    grp  = 2'd3;
                end
                else begin
                    phase = AWAIT_HDR3;
                end
            end
            AWAIT_HDR3: begin
                phase   = AWAIT_CODE;
                chan    = CH_RED;
                col_pos = '0;
            end
            AWAIT_CODE: begin
                if (b > RUN_THRESHOLD) begin
                    left  = {1'b0, b[6:0] & RUN_MASK};
                    phase = AWAIT_RUN_VALUE;
                end
                else if (b != 8'd0) begin
                    left  = b;
                    phase = AWAIT_LITERAL;
                end
            end
            AWAIT_RUN_VALUE: begin
                fill_columns(b, int'(left), w);
                left = '0;
                close_count(w);
            end
            AWAIT_LITERAL: begin
                fill_columns(b, 1, w);
                if (left > 8'd0) left = left - 8'd1;
                if (left == 8'd0) close_count(w);
            end
            default: ;
        endcase
    endfunction

    // ---------------- checking ----------------

    function automatic void check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Compare results, run the shadow on accepted bytes, watch for a hang
    always @(posedge clk) begin
        if (rst_n) begin
            activity = 1'b0;
            if (m_tvalid && m_tready) begin
                activity = 1'b1;
                if (pending_pixels.size() == 0) begin
                    $error("unexpected result: row %0d column %0d",
                           m_tdata[92:77], m_tdata[76:65]);
                    mismatches++;
                end
                else begin
                    want = pending_pixels.pop_front();
                    check_field("first_red",       want.first_red,       m_tdata[7:0]);
                    check_field("first_green",     want.first_green,     m_tdata[15:8]);
                    check_field("first_blue",      want.first_blue,      m_tdata[23:16]);
                    check_field("first_exponent",  want.first_exponent,  m_tdata[31:24]);
                    check_field("second_red",      want.second_red,      m_tdata[39:32]);
                    check_field("second_green",    want.second_green,    m_tdata[47:40]);
                    check_field("second_blue",     want.second_blue,     m_tdata[55:48]);
                    check_field("second_exponent", want.second_exponent, m_tdata[63:56]);
                    check_field("second_valid",    want.second_valid,    m_tdata[64]);
                    check_field("column",          want.column,          m_tdata[76:65]);
                    check_field("row",             want.row,             m_tdata[92:77]);
                    check_field("last_of_run",     want.last_of_run,     m_tlast);
                end
            end
            if (s_tvalid && s_tready) begin
                activity   = 1'b1;
                byte_taken = 1'b1;
                decode_byte(s_tdata, s_tuser[0]);
            end
            idle_cycles = activity ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------- idling ----------------

    function automatic int pick_gap(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Byte driver: hold until the transaction completes, then gap or advance
    always @(negedge clk) begin
        if (rst_n && (!s_tvalid || byte_taken)) begin
            byte_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (byte_stream.size() > 0) begin
                next_byte = byte_stream.pop_front();
                s_tdata  <= next_byte.data;
                s_tuser  <= next_byte.restart;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
                send_gap = pick_gap(send_calm);
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else if (hold_gap > 0) begin
            hold_gap--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
            if ($urandom_range(0, 3) == 0) hold_gap = pick_gap(take_calm);
        end
    end

    // ---------------- stimulus ----------------

    function automatic void send(logic [7:0] b);
        stream_byte_t it;
        it.data      = b;
        it.restart   = restart_next;
        restart_next = 1'b0;
        byte_stream.push_back(it);
        bytes_made++;
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // Code one channel of w columns as a mix of runs and literals
    function automatic void send_channel(int w, int lit_pct);
        int covered;
        int n;
        int k;
        int r;
        covered = 0;
        while (covered < w) begin
            r = $urandom_range(0, 99);
            n = w - covered;
            if (n > 127) n = 127;
            if (r < 3) begin
                // empty literal
                send(8'h00);
            end
            else if (r < 3 + lit_pct) begin
                if ((w - covered >= 128 && $urandom_range(0, 1) == 0) ||
                    $urandom_range(0, 59) == 0) begin
                    n = 128;
                end
                else begin
                    n = $urandom_range(1, (n > 12) ? 12 : n);
                end
                send(8'(n));
                for (k = 0; k < n; k++) send(rand_byte());
                covered += n;
            end
            else begin
                // runs occasionally spill past the end of the line
                if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 127);
                else if ($urandom_range(0, 1) == 0) n = $urandom_range(1, n);
                send(RUN_THRESHOLD | 8'(n));
                send(rand_byte());
                covered += n;
            end
        end
    endfunction

    function automatic void send_rle_image(int w, int rows, int lit_pct, bit damage);
        int row;
        int ch;
        int k;
        int dmg;
        bit first_bad;
        for (row = 0; row < rows; row++) begin
            dmg = damage ? $urandom_range(0, 15) : 15;
            if (dmg == 0) begin
                // broken header: the rest of the image is read as flat pixels
                first_bad = $urandom_range(0, 1);
                send(first_bad ? 8'($urandom_range(3, 255)) : HDR_MARK);
                send(HDR_MARK);
                send(first_bad ? rand_byte() : (8'h80 | rand_byte()));
                for (k = $urandom_range(1, 40); k > 0; k--) send(rand_byte());
                return;
            end
            send(HDR_MARK);
            send(HDR_MARK);
            send(rand_byte() & 8'h7f);
            send(rand_byte());
            if (dmg == 1) send(rand_byte());
            for (ch = 0; ch < 4; ch++) begin
                if (dmg == 2 && ch == 2) restart_next = 1'b1;
                send_channel(w, lit_pct);
            end
        end
    endfunction

    // ---------------- configuration ----------------

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_WIDTH) cfg_width = value[12:0];
        else cfg_height = value[15:0];
    endtask

    // Drain all bytes and results, then let the column sweep finish
    task automatic wait_idle();
        while (byte_stream.size() != 0 || s_tvalid || pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic begin_phase(input int w, input int h);
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        restart_next = 1'b1;
    endtask

    initial begin
        int w;
        int h;
        int r;
        int k;
        int first;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        idle_cycles = 0;
        bytes_made  = 0;
        byte_taken  = 1'b0;
        send_gap    = 0;
        hold_gap    = 0;
        send_calm   = 1'b0;
        take_calm   = 1'b0;
        restart_next = 1'b0;
        cfg_width   = 13'd8;
        cfg_height  = 16'd1;
        for (k = 0; k < MAX_COLS; k++) line_rgb[k] = '0;
        restart_parse();

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Two-line image: zero count, long run past the line end, run of one,
        // literals on the exponent channel, then a header with the high bit set
        begin_phase(8, 2);
        send(HDR_MARK); send(HDR_MARK); send(8'h00); send(8'h08);
        send(8'h88); send(8'hff);
        send(8'h00); send(8'hff); send(8'h00);
        send(8'h81); send(8'h01); send(8'h87); send(8'h80);
        send(8'h03); send(8'h00); send(8'h7f); send(8'hff);
        send(8'h85); send(8'h80);
        send(HDR_MARK); send(HDR_MARK); send(8'h80); send(8'h33);

        // Zero width and height act as one; bytes after the image are dropped
        begin_phase(0, 0);
        send(8'h11); send(8'h22); send(8'h33); send(8'h44);
        send(8'haa); send(8'hbb);

        // Widest lines, and a width register above the line store size
        begin_phase(MAX_COLS, 16'hffff);
        send_rle_image(MAX_COLS, 1, 1, 1'b0);
        begin_phase(13'h1fff, 1);
        send_rle_image(MAX_COLS, 1, 1, 1'b0);

        // Random images under random settings
        first = bytes_made;
        while (bytes_made - first < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 15) w = $urandom_range(1, MIN_RLE_COLS - 1);
            else if (r < 85) w = $urandom_range(MIN_RLE_COLS, 24);
            else w = $urandom_range(25, 300);
            r = $urandom_range(0, 99);
            if (r < 60) h = 1;
            else if (r < 90) h = $urandom_range(2, 3);
            else h = 4;
            begin_phase(w, h);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                for (k = $urandom_range(8, 40); k > 0; k--) begin
                    if ($urandom_range(0, 15) == 0) restart_next = 1'b1;
                    send(rand_byte());
                end
            end
            else if (w < MIN_RLE_COLS) begin
                for (k = 0; k < 4 * w * h; k++) send(rand_byte());
            end
            else begin
                send_rle_image(w, h, 45, 1'b1);
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
